// ===== rtl/core/freefall_exit_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Freefall exit detector assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef FREEFALL_EXIT_DETECTOR_MACROS_SVH
`define FREEFALL_EXIT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

`define FFED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffed assertion failed");

`define FFED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffed assertion failed");

`else

`define FFED_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define FFED_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ffed_pkg.sv =====
// ----------------------------------------------------------------------------
// Freefall exit detector package
// Shared types, codes and fixed widths of the detector and its divider.
// ----------------------------------------------------------------------------
package ffed_pkg;

    localparam int TS_W       = 48;
    localparam int VEL_W      = 24;
    localparam int ACC_W      = 20;
    localparam int GRAV_W     = 16;
    localparam int SLOPE_W    = 32;
    localparam int REL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_W      = 64;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 26;
    localparam int DX_CLAMP   = 1048576;

    localparam logic [TS_W-1:0] TS_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIMIT = 2'd1;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET   = 16'd9807;
    localparam logic [ACC_W-1:0]  ACC_LIMIT_RESET = 20'd10000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E0, ST_E1, ST_E2, ST_E3,
        ST_SX2, ST_SXSY, ST_SLN, ST_SDIV,
        ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_D7, ST_D8,
        ST_D9, ST_D10, ST_D11, ST_D12, ST_D13, ST_D14, ST_D15, ST_D16, ST_D17,
        ST_FINISH
    } ffed_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } ffed_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } ffed_div_rsp_t;

endpackage

// ===== rtl/core/ffed_div.sv =====
// ----------------------------------------------------------------------------
// Freefall exit detector divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ffed_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ffed_pkg::ffed_div_req_t req,
    output ffed_pkg::ffed_div_rsp_t rsp
);

    localparam int W     = ffed_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = trial[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== rtl/core/freefall_exit_detector.sv =====
// ----------------------------------------------------------------------------
// Freefall exit detector
// Sliding-window slope fit and gravity-crossing exit time estimate.
// ----------------------------------------------------------------------------
// Usage: GPS samples arrive on the s_ channel (timestamp, downward velocity,
// accuracy); every accepted transaction yields exactly one m_ transaction
// carrying the latched freefall flag, exit time and newest fitted slope.
// Registers gravity_mmps (index 0) and accuracy_limit (index 1) are written
// on the cfg channel while the block is idle, a rule for the user that the
// block does not enforce; cfg_ready is always high. When the window is not
// full or exit is latched, m_valid and s_ready rise together after accept.
// With a full window the slope fit loops through E0..E3 for every window entry,
// then SX2, SXSY, SLN and, for a positive denominator, a divide; detection adds
// up to 18 steps, three of which wait on a divide, all on one shared multiplier
// and one shared divider. s_ready is high only in idle, so no new sample is taken while one is in work.
// Reset restores the register defaults and empties the window.
// A stalled receiver holds the result in the output register; the next
// sample is still accepted and its result waits until the register frees.
// ----------------------------------------------------------------------------
`include "freefall_exit_detector_macros.svh"

module freefall_exit_detector #(
    parameter int WINDOW_LEN = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ffed_pkg::TS_W-1:0]           s_timestamp_ms,
    input  logic signed [ffed_pkg::VEL_W-1:0]   s_vel_down,
    input  logic [ffed_pkg::ACC_W-1:0]          s_accuracy,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_freefall,
    output logic [ffed_pkg::TS_W-1:0]           m_exit_time_ms,
    output logic signed [ffed_pkg::SLOPE_W-1:0] m_slope,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ffed_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffed_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam int P     = WINDOW_LEN - 2;
    localparam int C     = WINDOW_LEN - 1;
    localparam int TS_W  = ffed_pkg::TS_W;
    localparam int VEL_W = ffed_pkg::VEL_W;
    localparam int ACC_W = ffed_pkg::ACC_W;
    localparam int SL_W  = ffed_pkg::SLOPE_W;
    localparam int REL_W = ffed_pkg::REL_W;
    localparam int G_W   = ffed_pkg::GRAV_W;

    ffed_pkg::ffed_state_t state_reg, state_next;

    logic [G_W-1:0]           gravity_reg, gravity_next;
    logic [ACC_W-1:0]         lim_reg, lim_next;
    logic [TS_W-1:0]          start_time_reg, start_time_next;
    logic                     have_start_reg, have_start_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     detected_reg, detected_next;
    logic [TS_W-1:0]          exit_reg, exit_next;

    logic [REL_W-1:0]         rel_reg   [WINDOW_LEN];
    logic signed [VEL_W-1:0]  vel_reg   [WINDOW_LEN];
    logic [ACC_W-1:0]         accy_reg  [WINDOW_LEN];
    logic [TS_W-1:0]          ts_reg    [WINDOW_LEN];
    logic signed [SL_W-1:0]   accel_reg [WINDOW_LEN];

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [63:0]       prod_reg;
    logic signed [25:0]       sx_reg, sx_next;
    logic signed [27:0]       sy_reg, sy_next;
    logic signed [63:0]       nsxx_reg, nsxx_next;
    logic signed [63:0]       nsxy_reg, nsxy_next;
    logic signed [21:0]       dx_reg, dx_next;
    logic signed [VEL_W-1:0]  y_reg, y_next;
    logic signed [25:0]       ndx_reg, ndx_next;
    logic signed [63:0]       t_reg, t_next;
    logic                     neg_reg, neg_next;
    logic signed [63:0]       azn_reg, azn_next;
    logic [23:0]              num_reg, num_next;
    logic [23:0]              den_reg, den_next;
    logic                     dneg_reg, dneg_next;
    logic signed [49:0]       q_reg, q_next;
    logic [23:0]              r_reg, r_next;
    logic signed [63:0]       off_reg, off_next;
    logic [63:0]              fall_reg, fall_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     m_freefall_reg, m_freefall_next;
    logic [TS_W-1:0]          m_exit_reg, m_exit_next;
    logic signed [SL_W-1:0]   m_slope_reg, m_slope_next;

    logic signed [ffed_pkg::MUL_A_W-1:0]                   mul_a;
    logic signed [ffed_pkg::MUL_B_W-1:0]                   mul_b;
    logic signed [ffed_pkg::MUL_A_W+ffed_pkg::MUL_B_W-1:0] mul_p;

    logic                     shift_en;
    logic                     slope_wr;
    logic signed [SL_W-1:0]   slope_val;
    logic signed [32:0]       rdiff;
    logic signed [21:0]       dx_c;
    logic [REL_W-1:0]         rel_in;
    logic [TS_W:0]            ts_diff;
    logic                     full;

    ffed_pkg::ffed_div_req_t  div_req;
    ffed_pkg::ffed_div_rsp_t  div_rsp;

    ffed_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign mul_p     = mul_a * mul_b;
    assign s_ready   = (state_reg == ffed_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign full      = (count_reg == CNT_W'(WINDOW_LEN));

    assign ts_diff = {1'b0, s_timestamp_ms} - {1'b0, start_time_reg};
    always_comb begin
        if (ts_diff[TS_W]) begin
            rel_in = '0;
        end else if (|ts_diff[TS_W-1:REL_W]) begin
            rel_in = '1;
        end else begin
            rel_in = ts_diff[REL_W-1:0];
        end
    end

    assign rdiff = $signed({1'b0, rel_reg[idx_reg]}) - $signed({1'b0, rel_reg[0]});
    always_comb begin
        if (rdiff > $signed(33'(ffed_pkg::DX_CLAMP))) begin
            dx_c = 22'(ffed_pkg::DX_CLAMP);
        end else if (rdiff < -$signed(33'(ffed_pkg::DX_CLAMP))) begin
            dx_c = -22'(ffed_pkg::DX_CLAMP);
        end else begin
            dx_c = rdiff[21:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ffed_pkg::ST_IDLE;
            gravity_reg    <= ffed_pkg::GRAVITY_RESET;
            lim_reg        <= ffed_pkg::ACC_LIMIT_RESET;
            have_start_reg <= 1'b0;
            count_reg      <= '0;
            detected_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gravity_reg    <= gravity_next;
            lim_reg        <= lim_next;
            have_start_reg <= have_start_next;
            count_reg      <= count_next;
            detected_reg   <= detected_next;
            m_valid_reg    <= m_valid_next;
        end
        start_time_reg <= start_time_next;
        exit_reg       <= exit_next;
        idx_reg        <= idx_next;
        prod_reg       <= 64'(mul_p);
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        nsxx_reg       <= nsxx_next;
        nsxy_reg       <= nsxy_next;
        dx_reg         <= dx_next;
        y_reg          <= y_next;
        ndx_reg        <= ndx_next;
        t_reg          <= t_next;
        neg_reg        <= neg_next;
        azn_reg        <= azn_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        dneg_reg       <= dneg_next;
        q_reg          <= q_next;
        r_reg          <= r_next;
        off_reg        <= off_next;
        fall_reg       <= fall_next;
        m_freefall_reg <= m_freefall_next;
        m_exit_reg     <= m_exit_next;
        m_slope_reg    <= m_slope_next;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                rel_reg[i]   <= rel_reg[i+1];
                vel_reg[i]   <= vel_reg[i+1];
                accy_reg[i]  <= accy_reg[i+1];
                ts_reg[i]    <= ts_reg[i+1];
                accel_reg[i] <= accel_reg[i+1];
            end
            rel_reg[C]   <= rel_in;
            vel_reg[C]   <= s_vel_down;
            accy_reg[C]  <= s_accuracy;
            ts_reg[C]    <= s_timestamp_ms;
            accel_reg[C] <= '0;
        end else if (slope_wr) begin
            accel_reg[C] <= slope_val;
        end
    end

    always_comb begin
        logic signed [63:0] numraw;
        logic signed [63:0] num1000;
        logic [63:0]        mag;
        logic [63:0]        qs;
        logic signed [25:0] nm;
        logic signed [25:0] dn;
        logic signed [65:0] ex_s;
        logic [25:0]        g1000;

        numraw  = nsxy_reg - prod_reg;
        num1000 = (numraw <<< 10) - (numraw <<< 4) - (numraw <<< 3);
        mag     = num1000[63] ? 64'(-num1000) : 64'(num1000);
        qs      = div_rsp.quot;
        nm      = $signed(26'({1'b0, gravity_reg})) - 26'(vel_reg[P]);
        dn      = 26'(vel_reg[C]) - 26'(vel_reg[P]);
        ex_s    = $signed({18'b0, ts_reg[P]}) + 66'(off_reg) - $signed({2'b0, fall_reg});
        g1000   = ({10'b0, gravity_reg} << 10) - ({10'b0, gravity_reg} << 4)
                - ({10'b0, gravity_reg} << 3);

        state_next      = state_reg;
        gravity_next    = gravity_reg;
        lim_next        = lim_reg;
        start_time_next = start_time_reg;
        have_start_next = have_start_reg;
        count_next      = count_reg;
        detected_next   = detected_reg;
        exit_next       = exit_reg;
        idx_next        = idx_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        nsxx_next       = nsxx_reg;
        nsxy_next       = nsxy_reg;
        dx_next         = dx_reg;
        y_next          = y_reg;
        ndx_next        = ndx_reg;
        t_next          = t_reg;
        neg_next        = neg_reg;
        azn_next        = azn_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        dneg_next       = dneg_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        off_next        = off_reg;
        fall_next       = fall_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_freefall_next = m_freefall_reg;
        m_exit_next     = m_exit_reg;
        m_slope_next    = m_slope_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '0;
        shift_en        = 1'b0;
        slope_wr        = 1'b0;
        slope_val       = '0;

        if (cfg_valid) begin
            case (cfg_index)
                ffed_pkg::CFG_GRAVITY:   gravity_next = cfg_data[G_W-1:0];
                ffed_pkg::CFG_ACC_LIMIT: lim_next     = cfg_data[ACC_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ffed_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ffed_pkg::ST_FINISH;
                    if (!detected_reg) begin
                        if (!have_start_reg) begin
                            start_time_next = s_timestamp_ms;
                            have_start_next = 1'b1;
                        end else begin
                            shift_en = 1'b1;
                            if (!full) begin
                                count_next = count_reg + 1'b1;
                            end
                            if (count_reg >= CNT_W'(WINDOW_LEN - 1)) begin
                                idx_next   = '0;
                                sx_next    = '0;
                                sy_next    = '0;
                                nsxx_next  = '0;
                                nsxy_next  = '0;
                                state_next = ffed_pkg::ST_E0;
                            end
                        end
                    end
                end
            end
            ffed_pkg::ST_E0: begin
                mul_a      = ffed_pkg::MUL_A_W'(WINDOW_LEN);
                mul_b      = 26'(dx_c);
                dx_next    = dx_c;
                y_next     = vel_reg[idx_reg];
                sx_next    = sx_reg + 26'(dx_c);
                sy_next    = sy_reg + 28'(vel_reg[idx_reg]);
                state_next = ffed_pkg::ST_E1;
            end
            ffed_pkg::ST_E1: begin
                ndx_next   = prod_reg[25:0];
                mul_a      = 34'(dx_reg);
                mul_b      = prod_reg[25:0];
                state_next = ffed_pkg::ST_E2;
            end
            ffed_pkg::ST_E2: begin
                nsxx_next  = nsxx_reg + prod_reg;
                mul_a      = 34'(y_reg);
                mul_b      = ndx_reg;
                state_next = ffed_pkg::ST_E3;
            end
            ffed_pkg::ST_E3: begin
                nsxy_next = nsxy_reg + prod_reg;
                if (idx_reg == IDX_W'(C)) begin
                    state_next = ffed_pkg::ST_SX2;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ffed_pkg::ST_E0;
                end
            end
            ffed_pkg::ST_SX2: begin
                mul_a      = 34'(sx_reg);
                mul_b      = sx_reg;
                state_next = ffed_pkg::ST_SXSY;
            end
            ffed_pkg::ST_SXSY: begin
                t_next     = nsxx_reg - prod_reg;
                mul_a      = 34'(sy_reg);
                mul_b      = sx_reg;
                state_next = ffed_pkg::ST_SLN;
            end
            ffed_pkg::ST_SLN: begin
                if (t_reg <= 0) begin
                    slope_wr   = 1'b1;
                    slope_val  = '0;
                    state_next = ffed_pkg::ST_D0;
                end else begin
                    neg_next         = num1000[63];
                    div_req.start    = 1'b1;
                    div_req.dividend = mag + (64'(t_reg) >> 1);
                    div_req.divisor  = 64'(t_reg);
                    state_next       = ffed_pkg::ST_SDIV;
                end
            end
            ffed_pkg::ST_SDIV: begin
                if (div_rsp.done) begin
                    slope_wr = 1'b1;
                    if (neg_reg) begin
                        if (qs > 64'd2147483648) begin
                            qs = 64'd2147483648;
                        end
                        slope_val = SL_W'(-qs);
                    end else begin
                        if (qs > 64'd2147483647) begin
                            qs = 64'd2147483647;
                        end
                        slope_val = SL_W'(qs);
                    end
                    state_next = ffed_pkg::ST_D0;
                end
            end
            ffed_pkg::ST_D0: begin
                state_next = ffed_pkg::ST_FINISH;
                if (dn != 0) begin
                    if (dn < 0) begin
                        dn = -dn;
                        nm = -nm;
                    end
                    if (nm >= 0 && nm <= dn) begin
                        num_next   = nm[23:0];
                        den_next   = dn[23:0];
                        state_next = ffed_pkg::ST_D1;
                    end
                end
            end
            ffed_pkg::ST_D1: begin
                mul_a      = {14'b0, accy_reg[P]};
                mul_b      = {2'b0, den_reg};
                state_next = ffed_pkg::ST_D2;
            end
            ffed_pkg::ST_D2: begin
                t_next     = prod_reg;
                mul_a      = 34'($signed({1'b0, accy_reg[C]}) - $signed({1'b0, accy_reg[P]}));
                mul_b      = {2'b0, num_reg};
                state_next = ffed_pkg::ST_D3;
            end
            ffed_pkg::ST_D3: begin
                t_next     = t_reg + prod_reg;
                mul_a      = {14'b0, lim_reg};
                mul_b      = {2'b0, den_reg};
                state_next = ffed_pkg::ST_D4;
            end
            ffed_pkg::ST_D4: begin
                if (t_reg > prod_reg) begin
                    state_next = ffed_pkg::ST_FINISH;
                end else begin
                    mul_a      = 34'(accel_reg[P]);
                    mul_b      = {2'b0, den_reg};
                    state_next = ffed_pkg::ST_D5;
                end
            end
            ffed_pkg::ST_D5: begin
                t_next     = prod_reg;
                mul_a      = 34'(33'(accel_reg[C]) - 33'(accel_reg[P]));
                mul_b      = {2'b0, num_reg};
                state_next = ffed_pkg::ST_D6;
            end
            ffed_pkg::ST_D6: begin
                azn_next   = t_reg + prod_reg;
                mul_a      = {18'b0, gravity_reg};
                mul_b      = {2'b0, den_reg};
                state_next = ffed_pkg::ST_D7;
            end
            ffed_pkg::ST_D7: begin
                if (((azn_reg <<< 2) + azn_reg) < prod_reg) begin
                    state_next = ffed_pkg::ST_FINISH;
                end else begin
                    dneg_next        = (ts_reg[C] < ts_reg[P]);
                    div_req.start    = 1'b1;
                    div_req.dividend = (ts_reg[C] < ts_reg[P])
                                     ? 64'(ts_reg[P] - ts_reg[C])
                                     : 64'(ts_reg[C] - ts_reg[P]);
                    div_req.divisor  = 64'(den_reg);
                    state_next       = ffed_pkg::ST_D8;
                end
            end
            ffed_pkg::ST_D8: begin
                if (div_rsp.done) begin
                    if (dneg_reg && div_rsp.rem != 0) begin
                        q_next = -$signed(50'(div_rsp.quot) + 50'd1);
                        r_next = den_reg - div_rsp.rem[23:0];
                    end else if (dneg_reg) begin
                        q_next = -$signed(50'(div_rsp.quot));
                        r_next = '0;
                    end else begin
                        q_next = 50'(div_rsp.quot);
                        r_next = div_rsp.rem[23:0];
                    end
                    state_next = ffed_pkg::ST_D9;
                end
            end
            ffed_pkg::ST_D9: begin
                mul_a      = {10'b0, q_reg[23:0]};
                mul_b      = {2'b0, num_reg};
                state_next = ffed_pkg::ST_D10;
            end
            ffed_pkg::ST_D10: begin
                off_next   = prod_reg;
                mul_a      = 34'($signed(q_reg[49:24]));
                mul_b      = {2'b0, num_reg};
                state_next = ffed_pkg::ST_D11;
            end
            ffed_pkg::ST_D11: begin
                off_next   = off_reg + (prod_reg <<< 24);
                mul_a      = {10'b0, r_reg};
                mul_b      = {2'b0, num_reg};
                state_next = ffed_pkg::ST_D12;
            end
            ffed_pkg::ST_D12: begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(prod_reg);
                div_req.divisor  = 64'(den_reg);
                state_next       = ffed_pkg::ST_D13;
            end
            ffed_pkg::ST_D13: begin
                if (div_rsp.done) begin
                    off_next   = off_reg + $signed(div_rsp.quot);
                    state_next = ffed_pkg::ST_D14;
                end
            end
            ffed_pkg::ST_D14: begin
                if (gravity_reg != '0 && azn_reg > 0) begin
                    mul_a      = {8'b0, g1000};
                    mul_b      = {2'b0, den_reg};
                    state_next = ffed_pkg::ST_D15;
                end else begin
                    fall_next  = '0;
                    state_next = ffed_pkg::ST_D17;
                end
            end
            ffed_pkg::ST_D15: begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'(prod_reg);
                div_req.divisor  = 64'(azn_reg);
                state_next       = ffed_pkg::ST_D16;
            end
            ffed_pkg::ST_D16: begin
                if (div_rsp.done) begin
                    fall_next  = div_rsp.quot;
                    state_next = ffed_pkg::ST_D17;
                end
            end
            ffed_pkg::ST_D17: begin
                if (ex_s < 0) begin
                    exit_next = '0;
                end else if (ex_s > $signed({18'b0, ffed_pkg::TS_MAX})) begin
                    exit_next = ffed_pkg::TS_MAX;
                end else begin
                    exit_next = ex_s[TS_W-1:0];
                end
                detected_next = 1'b1;
                state_next    = ffed_pkg::ST_FINISH;
            end
            ffed_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_freefall_next = detected_reg;
                    m_exit_next     = detected_reg ? exit_reg : '0;
                    m_slope_next    = full ? accel_reg[C] : '0;
                    state_next      = ffed_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffed_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_freefall     = m_freefall_reg;
    assign m_exit_time_ms = m_exit_reg;
    assign m_slope        = m_slope_reg;

    `FFED_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FFED_ASSERT_NEXT(a_detect_sticky, aclk, aresetn, detected_reg, detected_reg)
    `FFED_ASSERT_NOW(a_exit_zero, aclk, aresetn, m_valid && !m_freefall, m_exit_time_ms == '0)
    `FFED_ASSERT_NOW(a_div_idle, aclk, aresetn, state_reg == ffed_pkg::ST_IDLE, !div_rsp.busy)

endmodule

// ===== test/freefall_exit_detector_test.sv =====
// ----------------------------------------------------------------------------
// Freefall exit detector testbench
// Drives GPS samples and register writes through valid/ready channels with
// random gaps and stalls. A behavioral predictor of the window, slope fit and
// crossing detection gives the expected transaction for each sample, and the
// result channel is checked field by field, in order.
// ----------------------------------------------------------------------------
module freefall_exit_detector_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WIN       = 4;
    localparam int  IDLE_MAX  = 20000;
    localparam int  SETTLE    = 20;
    localparam longint VEL_HI = 8388607;
    localparam longint VEL_LO = -8388608;

    typedef struct packed {
        logic                         freefall;
        logic [ffed_pkg::TS_W-1:0]    exit_time;
        logic [ffed_pkg::SLOPE_W-1:0] slope;
    } ffed_result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [ffed_pkg::TS_W-1:0]           s_timestamp_ms = '0;
    logic signed [ffed_pkg::VEL_W-1:0]   s_vel_down = '0;
    logic [ffed_pkg::ACC_W-1:0]          s_accuracy = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic                                m_freefall;
    logic [ffed_pkg::TS_W-1:0]           m_exit_time_ms;
    logic signed [ffed_pkg::SLOPE_W-1:0] m_slope;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [ffed_pkg::CFG_IDX_W-1:0]      cfg_index = ffed_pkg::CFG_GRAVITY;
    logic [ffed_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    ffed_result_t expected_q[$];
    int  errors = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  steady = 1'b0;
    longint ts_now = 0;

    // predictor state
    longint grav_cfg = 9807;
    longint lim_cfg = 10000;
    longint start_ts = 0;
    bit     started = 1'b0;
    int     fill = 0;
    longint rel_w[WIN];
    longint vel_w[WIN];
    longint acc_w[WIN];
    longint ts_w[WIN];
    longint az_w[WIN];
    bit     latched = 1'b0;
    longint exit_held = 0;

    freefall_exit_detector #(.WINDOW_LEN(WIN)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_timestamp_ms(s_timestamp_ms), .s_vel_down(s_vel_down),
        .s_accuracy(s_accuracy),
        .m_valid(m_valid), .m_ready(m_ready), .m_freefall(m_freefall),
        .m_exit_time_ms(m_exit_time_ms), .m_slope(m_slope),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint fitted_accel();
        longint sx, sy, sxx, sxy, dx, den, num, mag, q;
        sx = 0; sy = 0; sxx = 0; sxy = 0;
        for (int i = 0; i < WIN; i++) begin
            dx = rel_w[i] - rel_w[0];
            if (dx > ffed_pkg::DX_CLAMP) dx = ffed_pkg::DX_CLAMP;
            if (dx < -ffed_pkg::DX_CLAMP) dx = -ffed_pkg::DX_CLAMP;
            sx += dx;
            sy += vel_w[i];
            sxx += dx * dx;
            sxy += dx * vel_w[i];
        end
        den = WIN * sxx - sx * sx;
        num = (WIN * sxy - sx * sy) * 1000;
        if (den <= 0) return 0;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -q;
        return (q > 64'd2147483647) ? 64'sd2147483647 : q;
    endfunction

    function automatic void check_crossing();
        longint num, den, accn, azn, d, q, r, offset, fall, ex;
        num = grav_cfg - vel_w[WIN-2];
        den = vel_w[WIN-1] - vel_w[WIN-2];
        if (den == 0) return;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num < 0 || num > den) return;
        accn = acc_w[WIN-2] * den + num * (acc_w[WIN-1] - acc_w[WIN-2]);
        if (accn > lim_cfg * den) return;
        azn = az_w[WIN-2] * den + num * (az_w[WIN-1] - az_w[WIN-2]);
        if (5 * azn < grav_cfg * den) return;
        d = ts_w[WIN-1] - ts_w[WIN-2];
        q = floor_quot(d, den);
        r = d - q * den;
        offset = q * num + (r * num) / den;
        fall = 0;
        if (grav_cfg != 0 && azn > 0) fall = (grav_cfg * 1000 * den) / azn;
        ex = ts_w[WIN-2] + offset - fall;
        if (ex < 0) ex = 0;
        if (ex > longint'(ffed_pkg::TS_MAX)) ex = longint'(ffed_pkg::TS_MAX);
        exit_held = ex;
        latched = 1'b1;
    endfunction

    function automatic ffed_result_t advance_window(logic [ffed_pkg::TS_W-1:0] ts,
                                                    logic signed [ffed_pkg::VEL_W-1:0] vel,
                                                    logic [ffed_pkg::ACC_W-1:0] acc);
        ffed_result_t res;
        longint t, rel;
        t = longint'(ts);
        if (!latched) begin
            if (!started) begin
                start_ts = t;
                started = 1'b1;
            end else begin
                rel = (t >= start_ts) ? t - start_ts : 0;
                if (rel > 64'hFFFF_FFFF) rel = 64'hFFFF_FFFF;
                for (int i = 0; i < WIN - 1; i++) begin
                    rel_w[i] = rel_w[i+1];
                    vel_w[i] = vel_w[i+1];
                    acc_w[i] = acc_w[i+1];
                    ts_w[i]  = ts_w[i+1];
                    az_w[i]  = az_w[i+1];
                end
                rel_w[WIN-1] = rel;
                vel_w[WIN-1] = longint'(vel);
                acc_w[WIN-1] = longint'(acc);
                ts_w[WIN-1]  = t;
                az_w[WIN-1]  = 0;
                if (fill < WIN) fill++;
                if (fill >= WIN) begin
                    az_w[WIN-1] = fitted_accel();
                    check_crossing();
                end
            end
        end
        res.freefall  = latched;
        res.exit_time = latched ? exit_held[ffed_pkg::TS_W-1:0] : '0;
        res.slope     = (fill >= WIN) ? az_w[WIN-1][ffed_pkg::SLOPE_W-1:0] : '0;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin : result_check
        ffed_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: result transaction with none expected", $time);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_freefall !== want.freefall) begin
                    $display("%0t: freefall exp %0b act %0b", $time, want.freefall, m_freefall);
                    errors++;
                end
                if (m_exit_time_ms !== want.exit_time) begin
                    $display("%0t: exit_time exp %0d act %0d", $time, want.exit_time,
                             m_exit_time_ms);
                    errors++;
                end
                if (m_slope !== want.slope) begin
                    $display("%0t: slope exp %0d act %0d", $time, $signed(want.slope),
                             m_slope);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_MAX);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(longint ts, longint vel, longint acc);
        int gap;
        if (vel > VEL_HI) vel = VEL_HI;
        if (vel < VEL_LO) vel = VEL_LO;
        s_valid <= 1'b1;
        s_timestamp_ms <= ts[ffed_pkg::TS_W-1:0];
        s_vel_down <= vel[ffed_pkg::VEL_W-1:0];
        s_accuracy <= acc[ffed_pkg::ACC_W-1:0];
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(advance_window(s_timestamp_ms, s_vel_down, s_accuracy));
        samples_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ffed_pkg::CFG_IDX_W-1:0] idx,
                             logic [ffed_pkg::CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == ffed_pkg::CFG_GRAVITY) begin
            grav_cfg = longint'(data[ffed_pkg::GRAV_W-1:0]);
        end else if (idx == ffed_pkg::CFG_ACC_LIMIT) begin
            lim_cfg = longint'(data[ffed_pkg::ACC_W-1:0]);
        end
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // velocities step linearly from v0; timestamps advance by dt from ts_now
    task automatic send_ramp(int len, longint v0, longint dv, int dt,
                             longint acc_lo, longint acc_hi);
        for (int k = 0; k < len; k++) begin
            ts_now += dt;
            send_sample(ts_now, v0 + k * dv, $urandom_range(acc_hi, acc_lo));
        end
    endtask

    task automatic test_directed();
        write_reg(ffed_pkg::CFG_ACC_LIMIT, 32'd0);
        send_sample(1000, 0, 1);
        send_sample(500, VEL_LO, 1048575);
        send_sample(longint'(ffed_pkg::TS_MAX), VEL_HI, 1);
        send_sample(2000, 9807, 500);
        repeat (4) send_sample(3000, 9807, 700);
        send_sample(3100, 0, 3);
        send_sample(3200, 100, 3);
        send_sample(3300, 200, 3);
        send_sample(3400, 300, 3);
        send_sample(3500, 9000, 2000);
        send_sample(3600, 9500, 2000);
        send_sample(3700, 10000, 2000);
        send_sample(3800, 10500, 2000);
        send_sample(3900, 0, 0);
        send_sample(0, VEL_HI, 1048575);
        ts_now = 4000;
    endtask

    task automatic test_random(longint grav, int count, bit quiet);
        int sent;
        write_reg(ffed_pkg::CFG_GRAVITY,
                  {16'($urandom_range(0, 65535)), grav[ffed_pkg::GRAV_W-1:0]});
        write_reg(ffed_pkg::CFG_ACC_LIMIT, 32'd0);
        steady = quiet;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 7) begin
                int len;
                len = $urandom_range(4, 8);
                send_ramp(len, grav + $signed($urandom_range(0, 60000)) - 30000,
                          $signed($urandom_range(0, 8000)) - 4000,
                          $urandom_range(50, 1000), 1048575, 1);
                sent += len;
            end else begin
                if ($urandom_range(0, 1))
                    send_sample({$urandom, $urandom}, $signed($urandom),
                                $urandom_range(1048575, 1));
                else
                    send_sample(ts_now + $signed($urandom_range(0, 4000)) - 2000,
                                $signed($urandom), $urandom_range(1048575, 1));
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_exit();
        longint g;
        int tries;
        g = $urandom_range(0, 1) ? 9807 : 0;
        write_reg(ffed_pkg::CFG_GRAVITY, g[ffed_pkg::CFG_DATA_W-1:0]);
        write_reg(ffed_pkg::CFG_ACC_LIMIT, 32'hFFF_FFFFF);
        repeat (3) send_ramp(6, g + 3000, -1000, 100, 5000, 0);
        tries = 0;
        while (!latched && tries < 20) begin
            send_ramp(8, g - 3000 + $signed($urandom_range(0, 400)), 1000,
                      $urandom_range(80, 120), 5000, 0);
            tries++;
        end
        repeat (10) send_sample({$urandom, $urandom}, $signed($urandom), $urandom);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(9807, 450, 1'b0);
        test_random(0, 350, 1'b0);
        test_random(65535, 250, 1'b0);
        test_random(65535, 100, 1'b1);
        test_exit();
        drain();
        $display("covered %0d samples, %0d results, %0d register writes",
                 samples_sent, results_seen, reg_writes);
        $display("exit %0s, latched time %0d", latched ? "detected" : "not detected",
                 exit_held);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ffed_pkg.sv
rtl/core/ffed_div.sv
rtl/core/freefall_exit_detector.sv
test/freefall_exit_detector_test.sv
